// File: rtl/i2cmts_pkg.sv
// i2cmts_pkg: shared types and constants of the i2c master transfer sequencer
// used by the front, queue and back modules and by the top level
`default_nettype none

package i2cmts_pkg;

	localparam int BUF_DEPTH   = 256;
	localparam int BUF_AW      = $clog2(BUF_DEPTH);
	localparam int LEN_W       = 9;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int IN_TDATA_W  = 32;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 32;

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_EVENT = 2'd2;
	localparam logic [1:0] FUNC_ERROR = 2'd3;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_START,
		OP_EVENT,
		OP_ERROR,
		OP_NOP
	} op_kind_t;

	typedef enum logic [1:0] {
		EV_START_SENT,
		EV_ADDR_DONE,
		EV_DATA
	} ev_kind_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_NACK,
		ST_BUS_ERR,
		ST_ARB_LOST
	} status_t;

	typedef struct packed {
		op_kind_t         kind;
		logic [7:0]       data;
		logic [6:0]       addr;
		logic             rnw;
		logic [LEN_W-1:0] len;
		ev_kind_t         ev;
		logic             tx_empty;
		logic             rx_full;
		status_t          err;
	} op_t;

	typedef struct packed {
		logic       busy_res;
		status_t    status;
		logic       done_res;
		logic       clear_addr_flag;
		logic       clear_ack;
		logic       set_ack;
		logic       set_stop;
		logic       set_start;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic [7:0] dr_value;
		logic       write_dr;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/i2c_master_transfer_sequencer.sv
// an item's result appears after the front register, a queue entry and res_q
// throughput: the execute stage retires one op per cycle unless backpressured
// the transmit byte for the next data event is prefetched from a buffer with
// one write port and one registered read port
// reset: arst_n clears the transfer state to idle and empties the op queue
// the transmit buffer itself is not cleared, entries are valid once loaded
// top level, depends on i2cmts_pkg, i2cmts_front, i2cmts_queue, i2cmts_back
`default_nettype none

module i2c_master_transfer_sequencer (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// data_byte, target_addr, read_not_write, xfer_length, flag_start_sent,
	// flag_addr_done, flag_tx_empty, flag_rx_full, flag_nack, flag_bus_error,
	// flag_arb_lost
	input  wire logic [i2cmts_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// func
	input  wire logic [i2cmts_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// write_dr, dr_value, rx_valid, rx_byte, set_start, set_stop, set_ack,
	// clear_ack, clear_addr_flag, done_res, status, busy_res
	output logic [i2cmts_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

	logic            f_valid;
	logic            f_ready;
	i2cmts_pkg::op_t f_op;
	logic            q_valid;
	logic            q_ready;
	i2cmts_pkg::op_t q_op;

	i2cmts_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.op_valid      (f_valid),
		.op            (f_op),
		.op_ready      (f_ready)
	);

	i2cmts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_op    (f_op),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_op     (q_op)
	);

	i2cmts_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.op_valid      (q_valid),
		.op_ready      (q_ready),
		.op            (q_op),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

`default_nettype wire

// File: rtl/i2cmts_front.sv
// i2cmts_front: input stage, takes stream transfers and decodes them into ops
// depends on i2cmts_pkg
`default_nettype none

module i2cmts_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// data_byte, target_addr, read_not_write, xfer_length, flag_start_sent,
	// flag_addr_done, flag_tx_empty, flag_rx_full, flag_nack, flag_bus_error,
	// flag_arb_lost
	input  wire logic [i2cmts_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// func
	input  wire logic [i2cmts_pkg::IN_TUSER_W-1:0] s_axis_tuser,
	output logic                                   op_valid,
	output i2cmts_pkg::op_t                        op,
	input  wire logic                              op_ready
);

	logic            v_s1;
	i2cmts_pkg::op_t op_s1;
	i2cmts_pkg::op_t dec;

	always_comb begin
		dec          = '0;
		dec.kind     = i2cmts_pkg::OP_NOP;
		dec.data     = s_axis_tdata[7:0];
		dec.addr     = s_axis_tdata[14:8];
		dec.rnw      = s_axis_tdata[15];
		dec.len      = s_axis_tdata[24:16];
		dec.tx_empty = s_axis_tdata[27];
		dec.rx_full  = s_axis_tdata[28];
		priority if (s_axis_tdata[25]) begin
			dec.ev = i2cmts_pkg::EV_START_SENT;
		end else if (s_axis_tdata[26]) begin
			dec.ev = i2cmts_pkg::EV_ADDR_DONE;
		end else begin
			dec.ev = i2cmts_pkg::EV_DATA;
		end
		priority if (s_axis_tdata[29]) begin
			dec.err = i2cmts_pkg::ST_NACK;
		end else if (s_axis_tdata[30]) begin
			dec.err = i2cmts_pkg::ST_BUS_ERR;
		end else if (s_axis_tdata[31]) begin
			dec.err = i2cmts_pkg::ST_ARB_LOST;
		end else begin
			dec.err = i2cmts_pkg::ST_OK;
		end
		unique case (s_axis_tuser[1:0])
			i2cmts_pkg::FUNC_LOAD: begin
				dec.kind = i2cmts_pkg::OP_LOAD;
			end
			i2cmts_pkg::FUNC_START: begin
				dec.kind = (dec.len != '0) ? i2cmts_pkg::OP_START : i2cmts_pkg::OP_NOP;
			end
			i2cmts_pkg::FUNC_EVENT: begin
				dec.kind = i2cmts_pkg::OP_EVENT;
			end
			i2cmts_pkg::FUNC_ERROR: begin
				dec.kind = i2cmts_pkg::OP_ERROR;
			end
			default: begin
				dec.kind = i2cmts_pkg::OP_NOP;
			end
		endcase
	end

	assign s_axis_tready = !v_s1 || op_ready;
	assign op_valid      = v_s1;
	assign op            = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1 <= dec;
		end
	end

endmodule

`default_nettype wire

// File: rtl/i2cmts_queue.sv
// i2cmts_queue: short op queue between the decode front and the execute back
// depends on i2cmts_pkg
`default_nettype none

module i2cmts_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire i2cmts_pkg::op_t push_op,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output i2cmts_pkg::op_t      pop_op
);

	i2cmts_pkg::op_t                   entry_q [i2cmts_pkg::QUEUE_DEPTH];
	logic [i2cmts_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [i2cmts_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [i2cmts_pkg::QUEUE_CW-1:0]   count_q;
	logic                              push;
	logic                              pop;

	localparam logic [i2cmts_pkg::QUEUE_AW-1:0] LAST_PTR =
		i2cmts_pkg::QUEUE_AW'(i2cmts_pkg::QUEUE_DEPTH - 1);
	localparam logic [i2cmts_pkg::QUEUE_CW-1:0] FULL_COUNT =
		i2cmts_pkg::QUEUE_CW'(i2cmts_pkg::QUEUE_DEPTH);

	assign push_ready = (count_q != FULL_COUNT);
	assign pop_valid  = (count_q != '0);
	assign pop_op     = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

`default_nettype wire

// File: rtl/i2cmts_back.sv
// i2cmts_back: executes ops, holds transfer state and the transmit buffer,
// drives the registered result stream; depends on i2cmts_pkg
`default_nettype none

module i2cmts_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               op_valid,
	output logic                                    op_ready,
	input  wire i2cmts_pkg::op_t                    op,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// write_dr, dr_value, rx_valid, rx_byte, set_start, set_stop, set_ack,
	// clear_ack, clear_addr_flag, done_res, status, busy_res
	output logic [i2cmts_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

	localparam int RES_W = $bits(i2cmts_pkg::result_t);

	logic [7:0]                         buf_mem [i2cmts_pkg::BUF_DEPTH];
	logic [7:0]                         rd_data_q;
	logic [i2cmts_pkg::BUF_AW-1:0]      load_ptr_q;
	logic [i2cmts_pkg::BUF_AW-1:0]      load_ptr_d;
	logic [i2cmts_pkg::LEN_W-1:0]       byte_index_q;
	logic [i2cmts_pkg::LEN_W-1:0]       byte_index_d;
	logic [i2cmts_pkg::LEN_W-1:0]       byte_count_q;
	logic [i2cmts_pkg::LEN_W-1:0]       byte_count_d;
	logic [i2cmts_pkg::LEN_W-1:0]       index_inc;
	logic [6:0]                         slave_addr_q;
	logic [6:0]                         slave_addr_d;
	logic                               is_read_q;
	logic                               is_read_d;
	logic                               active_q;
	logic                               active_d;
	logic                               m_valid_q;
	i2cmts_pkg::result_t                res;
	i2cmts_pkg::result_t                res_q;
	logic                               take;
	logic                               wr_en;
	logic [i2cmts_pkg::BUF_AW-1:0]      rd_addr;

	assign op_ready      = !m_valid_q || m_axis_tready;
	assign take          = op_valid && op_ready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(i2cmts_pkg::OUT_TDATA_W - RES_W){1'b0}}, res_q};
	assign index_inc     = byte_index_q + 1'b1;
	assign wr_en         = take && (op.kind == i2cmts_pkg::OP_LOAD);
	assign rd_addr       = byte_index_d[i2cmts_pkg::BUF_AW-1:0];

	always_comb begin
		res          = '0;
		load_ptr_d   = load_ptr_q;
		byte_index_d = byte_index_q;
		byte_count_d = byte_count_q;
		slave_addr_d = slave_addr_q;
		is_read_d    = is_read_q;
		active_d     = active_q;
		if (take) begin
			unique case (op.kind)
				i2cmts_pkg::OP_LOAD: begin
					load_ptr_d = load_ptr_q + 1'b1;
				end
				i2cmts_pkg::OP_START: begin
					slave_addr_d  = op.addr;
					is_read_d     = op.rnw;
					byte_count_d  = op.len;
					byte_index_d  = '0;
					load_ptr_d    = '0;
					active_d      = 1'b1;
					res.set_start = 1'b1;
					res.set_ack   = op.rnw;
				end
				i2cmts_pkg::OP_EVENT: begin
					if (active_q) begin
						unique case (op.ev)
							i2cmts_pkg::EV_START_SENT: begin
								res.write_dr = 1'b1;
								res.dr_value = {slave_addr_q, is_read_q};
							end
							i2cmts_pkg::EV_ADDR_DONE: begin
								res.clear_addr_flag = 1'b1;
								if (is_read_q && byte_count_q == i2cmts_pkg::LEN_W'(1)) begin
									res.clear_ack = 1'b1;
									res.set_stop  = 1'b1;
								end
							end
							default: begin
								if (!is_read_q && op.tx_empty) begin
									if (byte_index_q < byte_count_q) begin
										res.write_dr = 1'b1;
										res.dr_value = rd_data_q;
										byte_index_d = index_inc;
									end else begin
										res.set_stop = 1'b1;
										res.done_res = 1'b1;
										active_d     = 1'b0;
									end
								end else if (is_read_q && op.rx_full) begin
									res.rx_valid = 1'b1;
									res.rx_byte  = op.data;
									byte_index_d = index_inc;
									if (index_inc >= byte_count_q) begin
										res.done_res = 1'b1;
										active_d     = 1'b0;
									end else if (index_inc == byte_count_q - 1'b1) begin
										res.clear_ack = 1'b1;
										res.set_stop  = 1'b1;
									end
								end
							end
						endcase
					end
				end
				i2cmts_pkg::OP_ERROR: begin
					if (active_q && op.err != i2cmts_pkg::ST_OK) begin
						res.done_res = 1'b1;
						res.status   = op.err;
						res.set_stop = (op.err != i2cmts_pkg::ST_ARB_LOST);
						active_d     = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
		res.busy_res = active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ptr_q   <= '0;
			byte_index_q <= '0;
			byte_count_q <= '0;
			slave_addr_q <= '0;
			is_read_q    <= 1'b0;
			active_q     <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			load_ptr_q   <= load_ptr_d;
			byte_index_q <= byte_index_d;
			byte_count_q <= byte_count_d;
			slave_addr_q <= slave_addr_d;
			is_read_q    <= is_read_d;
			active_q     <= active_d;
			if (take) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

	// prefetch of the entry at the next byte index, with write bypass
	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_mem[load_ptr_q] <= op.data;
		end
		if (wr_en && load_ptr_q == rd_addr) begin
			rd_data_q <= op.data;
		end else begin
			rd_data_q <= buf_mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/i2cmts_checker.sv
// i2cmts_checker: port-level assertions on the result stream of the sequencer
// depends on i2cmts_pkg, bound to i2c_master_transfer_sequencer
`default_nettype none

module i2cmts_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	input  wire logic [i2cmts_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// stalled result transfer holds its data
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// error status only with done
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[25:24] != 2'd0 |-> m_axis_tdata[23])
		else $error("status without done");

	// done leaves the block idle
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[23] |-> !m_axis_tdata[26])
		else $error("busy after done");

	// start request leaves the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[18] |-> m_axis_tdata[26])
		else $error("start without busy");

	// data register write and received byte never in one result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[9]))
		else $error("write and receive in one result");

endmodule

bind i2c_master_transfer_sequencer i2cmts_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: verif/i2c_master_transfer_sequencer_tb.sv
// testbench for i2c_master_transfer_sequencer: a directed table, then 1400 random items,
// checked field by field against the table's results or a predictor of the sequencer
// depends on i2cmts_pkg and the i2c_master_transfer_sequencer rtl only
module i2c_master_transfer_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1400;
	localparam int CALM_FROM    = 1250;
	localparam int SCRIPT_LEN   = 25;
	localparam int QUIET_LIMIT  = 1000;
	localparam int RES_W        = $bits(i2cmts_pkg::result_t);

	localparam logic [6:0] FLG_NONE = 7'h00;
	localparam logic [6:0] FLG_SS   = 7'h01;
	localparam logic [6:0] FLG_ADDR = 7'h02;
	localparam logic [6:0] FLG_TXE  = 7'h04;
	localparam logic [6:0] FLG_RXF  = 7'h08;
	localparam logic [6:0] FLG_NACK = 7'h10;
	localparam logic [6:0] FLG_BUS  = 7'h20;
	localparam logic [6:0] FLG_ARB  = 7'h40;
	localparam logic [6:0] FLG_ALL  = 7'h7f;

	// s_axis_tdata fields, lowest bit last
	typedef struct packed {
		logic       flag_arb_lost;
		logic       flag_bus_error;
		logic       flag_nack;
		logic       flag_rx_full;
		logic       flag_tx_empty;
		logic       flag_addr_done;
		logic       flag_start_sent;
		logic [8:0] xfer_length;
		logic       read_not_write;
		logic [6:0] target_addr;
		logic [7:0] data_byte;
	} bus_word_t;

	typedef struct packed {
		logic [1:0]          func;
		bus_word_t           word;
		bit                  typed;
		i2cmts_pkg::result_t want;
	} script_row_t;

	typedef enum logic [1:0] {
		PH_ADDR_BYTE,
		PH_ADDR_ACK,
		PH_DATA
	} xfer_phase_t;

	logic                               clk;
	logic                               arst_n        = 1'b0;
	logic                               s_axis_tvalid = 1'b0;
	logic                               s_axis_tready;
	logic [i2cmts_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic [i2cmts_pkg::IN_TUSER_W-1:0]  s_axis_tuser  = '0;
	logic                               m_axis_tvalid;
	logic                               m_axis_tready = 1'b0;
	logic [i2cmts_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	// sequencer state as predicted
	logic [7:0]                    tx_bytes [i2cmts_pkg::BUF_DEPTH];
	bit [i2cmts_pkg::BUF_DEPTH-1:0] loaded = '0;
	logic [i2cmts_pkg::BUF_AW-1:0] fill_ptr    = '0;
	logic [i2cmts_pkg::LEN_W-1:0]  xfer_idx    = '0;
	logic [i2cmts_pkg::LEN_W-1:0]  xfer_count  = '0;
	logic [6:0]                    xfer_addr   = '0;
	logic                          xfer_read   = 1'b0;
	logic                          xfer_active = 1'b0;

	xfer_phase_t gen_phase = PH_ADDR_BYTE;
	bit          gen_clean = 1'b1;
	bit          calm      = 1'b0;
	int          src_gap_pct = 20;
	int          snk_gap_pct = 20;
	int          snk_hold    = 0;
	int          quiet_cycles = 0;

	i2cmts_pkg::result_t pending_outcomes [$];
	int      fail_count   = 0;
	int      items_sent   = 0;
	int      results_seen = 0;
	int      bytes_out    = 0;
	int      bytes_in     = 0;
	int      ends_by_status [4] = '{0, 0, 0, 0};

	script_row_t script [SCRIPT_LEN];

	i2c_master_transfer_sequencer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic i2cmts_pkg::result_t sequence_step(input logic [1:0] func,
			input bus_word_t w);
		i2cmts_pkg::result_t r;
		r = '0;
		case (func)
			i2cmts_pkg::FUNC_LOAD: begin
				tx_bytes[fill_ptr] = w.data_byte;
				loaded[fill_ptr] = 1'b1;
				fill_ptr = fill_ptr + 1'b1;
			end
			i2cmts_pkg::FUNC_START: begin
				if (w.xfer_length != '0) begin
					xfer_addr   = w.target_addr;
					xfer_read   = w.read_not_write;
					xfer_count  = w.xfer_length;
					xfer_idx    = '0;
					fill_ptr    = '0;
					xfer_active = 1'b1;
					r.set_start = 1'b1;
					r.set_ack   = w.read_not_write;
				end
			end
			i2cmts_pkg::FUNC_EVENT: begin
				if (!xfer_active) begin
				end else if (w.flag_start_sent) begin
					r.write_dr = 1'b1;
					r.dr_value = {xfer_addr, xfer_read};
				end else if (w.flag_addr_done) begin
					r.clear_addr_flag = 1'b1;
					if (xfer_read && xfer_count == 9'd1) begin
						r.clear_ack = 1'b1;
						r.set_stop  = 1'b1;
					end
				end else if (!xfer_read && w.flag_tx_empty) begin
					if (xfer_idx < xfer_count) begin
						r.write_dr = 1'b1;
						r.dr_value = tx_bytes[xfer_idx[i2cmts_pkg::BUF_AW-1:0]];
						xfer_idx = xfer_idx + 1'b1;
					end else begin
						r.set_stop  = 1'b1;
						r.done_res  = 1'b1;
						r.status    = i2cmts_pkg::ST_OK;
						xfer_active = 1'b0;
					end
				end else if (xfer_read && w.flag_rx_full) begin
					r.rx_valid = 1'b1;
					r.rx_byte  = w.data_byte;
					xfer_idx = xfer_idx + 1'b1;
					if (xfer_idx >= xfer_count) begin
						r.done_res  = 1'b1;
						r.status    = i2cmts_pkg::ST_OK;
						xfer_active = 1'b0;
					end else if (xfer_idx == xfer_count - 1'b1) begin
						r.clear_ack = 1'b1;
						r.set_stop  = 1'b1;
					end
				end
			end
			default: begin
				if (xfer_active && (w.flag_nack || w.flag_bus_error || w.flag_arb_lost)) begin
					r.done_res  = 1'b1;
					xfer_active = 1'b0;
					if (w.flag_nack) begin
						r.set_stop = 1'b1;
						r.status   = i2cmts_pkg::ST_NACK;
					end else if (w.flag_bus_error) begin
						r.set_stop = 1'b1;
						r.status   = i2cmts_pkg::ST_BUS_ERR;
					end else begin
						r.status   = i2cmts_pkg::ST_ARB_LOST;
					end
				end
			end
		endcase
		r.busy_res = xfer_active;
		return r;
	endfunction

	function automatic script_row_t row(input logic [1:0] func, input logic [6:0] flags,
			input logic [8:0] len, input logic rnw, input logic [6:0] addr,
			input logic [7:0] data);
		script_row_t r;
		r.func  = func;
		r.word  = bus_word_t'({flags, len, rnw, addr, data});
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	function automatic script_row_t fixed(input script_row_t r,
			input i2cmts_pkg::result_t want);
		script_row_t f;
		f = r;
		f.typed = 1'b1;
		f.want  = want;
		return f;
	endfunction

	function automatic i2cmts_pkg::result_t outcome(input int busy, input int start,
			input int sack, input int stop, input int cack, input int caddr, input int done,
			input i2cmts_pkg::status_t st, input int wr, input logic [7:0] dr);
		i2cmts_pkg::result_t r;
		r = '0;
		r.busy_res        = busy[0];
		r.set_start       = start[0];
		r.set_ack         = sack[0];
		r.set_stop        = stop[0];
		r.clear_ack       = cack[0];
		r.clear_addr_flag = caddr[0];
		r.done_res        = done[0];
		r.status          = st;
		r.write_dr        = wr[0];
		r.dr_value        = dr;
		return r;
	endfunction

	function automatic logic [8:0] pick_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			return 9'd256;
		else if (roll < 15)
			return 9'($urandom_range(0, 256));
		return 9'($urandom_range(1, 8));
	endfunction

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("[%0t] result %0d: %s", $realtime, results_seen, what);
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
	endtask

	task automatic check_outcome(input logic [i2cmts_pkg::OUT_TDATA_W-1:0] bus);
		i2cmts_pkg::result_t got;
		i2cmts_pkg::result_t want;
		got = i2cmts_pkg::result_t'(bus[RES_W-1:0]);
		if (pending_outcomes.size() == 0) begin
			report_mismatch($sformatf("unexpected transfer 0x%0h", bus));
		end else begin
			want = pending_outcomes.pop_front();
			check_field("write_dr", 8'(got.write_dr), 8'(want.write_dr));
			check_field("dr_value", got.dr_value, want.dr_value);
			check_field("rx_valid", 8'(got.rx_valid), 8'(want.rx_valid));
			check_field("rx_byte", got.rx_byte, want.rx_byte);
			check_field("set_start", 8'(got.set_start), 8'(want.set_start));
			check_field("set_stop", 8'(got.set_stop), 8'(want.set_stop));
			check_field("set_ack", 8'(got.set_ack), 8'(want.set_ack));
			check_field("clear_ack", 8'(got.clear_ack), 8'(want.clear_ack));
			check_field("clear_addr_flag", 8'(got.clear_addr_flag),
				8'(want.clear_addr_flag));
			check_field("done_res", 8'(got.done_res), 8'(want.done_res));
			check_field("status", 8'(got.status), 8'(want.status));
			check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
			check_field("padding", 8'(bus[i2cmts_pkg::OUT_TDATA_W-1:RES_W]), 8'd0);
			bytes_out += int'(want.write_dr);
			bytes_in  += int'(want.rx_valid);
			if (want.done_res)
				ends_by_status[want.status]++;
		end
		results_seen++;
	endtask

	task automatic send_item(input logic [1:0] func, input bus_word_t w, input bit typed,
			input i2cmts_pkg::result_t want);
		i2cmts_pkg::result_t res;
		if (!calm && $urandom_range(1, 100) <= src_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= w;
		s_axis_tuser  <= func;
		do @(posedge clk); while (!s_axis_tready);
		res = sequence_step(func, w);
		if (res.set_start) begin
			gen_phase = PH_ADDR_BYTE;
			gen_clean = $urandom_range(0, 3) != 0;
		end else if (func == i2cmts_pkg::FUNC_EVENT && res.write_dr && w.flag_start_sent) begin
			gen_phase = PH_ADDR_ACK;
		end else if (res.clear_addr_flag) begin
			gen_phase = PH_DATA;
		end
		pending_outcomes.push_back(typed ? want : res);
		items_sent++;
	endtask

	task automatic make_item(output logic [1:0] func, output bus_word_t w);
		int roll;
		roll = $urandom_range(0, 99);
		w = bus_word_t'($urandom);
		w.xfer_length = pick_len();
		if (roll < 5) begin
			func = 2'($urandom_range(0, 3));
		end else begin
			w = bus_word_t'({FLG_NONE, w[24:0]});
			if (!xfer_active) begin
				func = (roll < 40) ? i2cmts_pkg::FUNC_LOAD : i2cmts_pkg::FUNC_START;
			end else if (!gen_clean && roll < 10) begin
				func = i2cmts_pkg::FUNC_ERROR;
				{w.flag_arb_lost, w.flag_bus_error, w.flag_nack} = 3'($urandom_range(0, 7));
			end else if (!gen_clean && roll < 13) begin
				func = i2cmts_pkg::FUNC_START;
			end else if (roll < 20) begin
				func = i2cmts_pkg::FUNC_LOAD;
			end else begin
				func = i2cmts_pkg::FUNC_EVENT;
				case (gen_phase)
					PH_ADDR_BYTE: w.flag_start_sent = 1'b1;
					PH_ADDR_ACK:  w.flag_addr_done  = 1'b1;
					default: begin
						w.flag_rx_full  = xfer_read  || $urandom_range(0, 3) == 0;
						w.flag_tx_empty = !xfer_read || $urandom_range(0, 3) == 0;
					end
				endcase
			end
		end
		// a byte is only sent once its buffer entry holds data
		if (func == i2cmts_pkg::FUNC_EVENT && xfer_active && !xfer_read &&
				!w.flag_start_sent && !w.flag_addr_done && w.flag_tx_empty &&
				xfer_idx < xfer_count && !loaded[xfer_idx[i2cmts_pkg::BUF_AW-1:0]])
			func = i2cmts_pkg::FUNC_LOAD;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_outcome(m_axis_tdata);
		if (snk_hold == 0 && !calm && $urandom_range(1, 100) <= snk_gap_pct)
			snk_hold = $urandom_range(1, 4);
		if (snk_hold > 0) begin
			snk_hold--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] no transfer for %0d cycles, %0d results outstanding",
				$realtime, QUIET_LIMIT, pending_outcomes.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int i;
		int k;
		logic [1:0] func;
		bus_word_t  w;

		script[0]  = fixed(row(i2cmts_pkg::FUNC_EVENT, FLG_ALL, 9'd256, 1'b1, 7'h7f, 8'hff),
			outcome(0, 0, 0, 0, 0, 0, 0, i2cmts_pkg::ST_OK, 0, 8'h00));
		script[1]  = fixed(row(i2cmts_pkg::FUNC_ERROR, FLG_ALL, 9'd0, 1'b0, 7'h00, 8'h00),
			outcome(0, 0, 0, 0, 0, 0, 0, i2cmts_pkg::ST_OK, 0, 8'h00));
		script[2]  = fixed(row(i2cmts_pkg::FUNC_START, FLG_NONE, 9'd0, 1'b1, 7'h7f, 8'hff),
			outcome(0, 0, 0, 0, 0, 0, 0, i2cmts_pkg::ST_OK, 0, 8'h00));
		script[3]  = fixed(row(i2cmts_pkg::FUNC_LOAD, FLG_NONE, 9'd0, 1'b0, 7'h00, 8'h00),
			outcome(0, 0, 0, 0, 0, 0, 0, i2cmts_pkg::ST_OK, 0, 8'h00));
		script[4]  = fixed(row(i2cmts_pkg::FUNC_LOAD, FLG_ALL, 9'd256, 1'b1, 7'h7f, 8'hff),
			outcome(0, 0, 0, 0, 0, 0, 0, i2cmts_pkg::ST_OK, 0, 8'h00));
		script[5]  = row(i2cmts_pkg::FUNC_LOAD, FLG_NONE, 9'd0, 1'b0, 7'h00, 8'ha5);
		script[6]  = fixed(row(i2cmts_pkg::FUNC_START, FLG_NONE, 9'd3, 1'b0, 7'h7f, 8'h00),
			outcome(1, 1, 0, 0, 0, 0, 0, i2cmts_pkg::ST_OK, 0, 8'h00));
		script[7]  = fixed(row(i2cmts_pkg::FUNC_EVENT, FLG_ALL, 9'd0, 1'b0, 7'h00, 8'h00),
			outcome(1, 0, 0, 0, 0, 0, 0, i2cmts_pkg::ST_OK, 1, 8'hfe));
		script[8]  = fixed(row(i2cmts_pkg::FUNC_EVENT, FLG_ADDR | FLG_TXE | FLG_RXF, 9'd0,
			1'b0, 7'h00, 8'h00), outcome(1, 0, 0, 0, 0, 1, 0, i2cmts_pkg::ST_OK, 0, 8'h00));
		script[9]  = row(i2cmts_pkg::FUNC_EVENT, FLG_TXE | FLG_RXF, 9'd0, 1'b0, 7'h00, 8'h33);
		script[10] = row(i2cmts_pkg::FUNC_EVENT, FLG_TXE, 9'd0, 1'b0, 7'h00, 8'h00);
		script[11] = row(i2cmts_pkg::FUNC_LOAD, FLG_NONE, 9'd0, 1'b0, 7'h00, 8'h3c);
		script[12] = row(i2cmts_pkg::FUNC_EVENT, FLG_TXE, 9'd0, 1'b0, 7'h00, 8'h00);
		script[13] = fixed(row(i2cmts_pkg::FUNC_EVENT, FLG_TXE, 9'd0, 1'b0, 7'h00, 8'h00),
			outcome(0, 0, 0, 1, 0, 0, 1, i2cmts_pkg::ST_OK, 0, 8'h00));
		script[14] = fixed(row(i2cmts_pkg::FUNC_START, FLG_NONE, 9'd1, 1'b1, 7'h00, 8'h00),
			outcome(1, 1, 1, 0, 0, 0, 0, i2cmts_pkg::ST_OK, 0, 8'h00));
		script[15] = fixed(row(i2cmts_pkg::FUNC_EVENT, FLG_SS, 9'd0, 1'b0, 7'h00, 8'h00),
			outcome(1, 0, 0, 0, 0, 0, 0, i2cmts_pkg::ST_OK, 1, 8'h01));
		script[16] = fixed(row(i2cmts_pkg::FUNC_EVENT, FLG_ADDR, 9'd0, 1'b0, 7'h00, 8'h00),
			outcome(1, 0, 0, 1, 1, 1, 0, i2cmts_pkg::ST_OK, 0, 8'h00));
		script[17] = row(i2cmts_pkg::FUNC_EVENT, FLG_RXF | FLG_TXE, 9'd0, 1'b0, 7'h00, 8'h5a);
		script[18] = fixed(row(i2cmts_pkg::FUNC_START, FLG_NONE, 9'd256, 1'b1, 7'h55, 8'h00),
			outcome(1, 1, 1, 0, 0, 0, 0, i2cmts_pkg::ST_OK, 0, 8'h00));
		script[19] = fixed(row(i2cmts_pkg::FUNC_START, FLG_NONE, 9'd2, 1'b0, 7'h2a, 8'h00),
			outcome(1, 1, 0, 0, 0, 0, 0, i2cmts_pkg::ST_OK, 0, 8'h00));
		script[20] = fixed(row(i2cmts_pkg::FUNC_ERROR, FLG_ALL, 9'd0, 1'b0, 7'h00, 8'h00),
			outcome(0, 0, 0, 1, 0, 0, 1, i2cmts_pkg::ST_NACK, 0, 8'h00));
		script[21] = row(i2cmts_pkg::FUNC_START, FLG_NONE, 9'd3, 1'b1, 7'h01, 8'h00);
		script[22] = fixed(row(i2cmts_pkg::FUNC_ERROR, FLG_BUS | FLG_ARB, 9'd0, 1'b0, 7'h00,
			8'h00), outcome(0, 0, 0, 1, 0, 0, 1, i2cmts_pkg::ST_BUS_ERR, 0, 8'h00));
		script[23] = row(i2cmts_pkg::FUNC_START, FLG_NONE, 9'd1, 1'b0, 7'h03, 8'h00);
		script[24] = fixed(row(i2cmts_pkg::FUNC_ERROR, FLG_ARB | FLG_NACK & FLG_NONE, 9'd0,
			1'b0, 7'h00, 8'h00),
			outcome(0, 0, 0, 0, 0, 0, 1, i2cmts_pkg::ST_ARB_LOST, 0, 8'h00));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < SCRIPT_LEN; i++)
			send_item(script[i].func, script[i].word, script[i].typed, script[i].want);

		// hold off until the directed results have drained
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_outcomes.size() != 0);

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 100 == 0) begin
				src_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
				snk_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
			end
			if (k == RANDOM_ITEMS / 2) begin
				s_axis_tvalid <= 1'b0;
				do @(posedge clk); while (pending_outcomes.size() != 0);
			end
			if (k == CALM_FROM)
				calm = 1'b1;
			make_item(func, w);
			send_item(func, w, 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;

		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d items, checked %0d results: %0d bytes written, %0d bytes received",
			items_sent, results_seen, bytes_out, bytes_in);
		$display("transfers ended: %0d ok, %0d nack, %0d bus error, %0d arbitration lost",
			ends_by_status[i2cmts_pkg::ST_OK], ends_by_status[i2cmts_pkg::ST_NACK],
			ends_by_status[i2cmts_pkg::ST_BUS_ERR], ends_by_status[i2cmts_pkg::ST_ARB_LOST]);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: i2c_master_transfer_sequencer.f
rtl/i2cmts_pkg.sv
rtl/i2cmts_front.sv
rtl/i2cmts_queue.sv
rtl/i2cmts_back.sv
rtl/i2c_master_transfer_sequencer.sv
rtl/i2cmts_checker.sv
verif/i2c_master_transfer_sequencer_tb.sv
